// File: sv/sfcd_pkg.sv
package sfcd_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HDR_BAD  = 3'd1;
    localparam logic [2:0] ST_PAY_BAD  = 3'd2;
    localparam logic [2:0] ST_OVERSIZE = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [7:0] CFG_FIRST_SYNC  = 8'd0;
    localparam logic [7:0] CFG_SECOND_SYNC = 8'd1;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'hFF;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'h55;

    typedef struct packed {
        logic       hsum_set;
        logic       hsum_add;
        logic       size_set;
        logic       pay_clear;
        logic       pay_write;
        logic       rd_clear;
        logic       rd_issue;
        logic       out_data;
        logic       out_status;
        logic [2:0] code;
    } sfcd_cmd_t;

    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic hdr_ok;
        logic size_zero;
        logic size_over;
        logic pay_done;
        logic pay_ok;
        logic rd_last;
        logic out_free;
    } sfcd_sts_t;

endpackage

// File: sv/sfcd_ram.sv
module sfcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/sfcd_ctrl.sv
module sfcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  sfcd_pkg::sfcd_sts_t sts,
    output sfcd_pkg::sfcd_cmd_t cmd
);

    localparam logic [2:0] S_SYNC1 = 3'd0;
    localparam logic [2:0] S_SYNC2 = 3'd1;
    localparam logic [2:0] S_SIZE  = 3'd2;
    localparam logic [2:0] S_HCHK  = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;
    localparam logic [2:0] S_PCHK  = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_LOAD  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_phase;
    logic       accept;

    assign in_phase = (state_reg != S_RD) && (state_reg != S_LOAD);
    assign rx_ready = in_phase && sts.out_free;
    assign accept   = rx_valid && rx_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = sfcd_pkg::ST_OK;
        unique case (state_reg)
            S_SYNC1:
            begin
                if (accept && sts.sync1_hit)
                begin
                    cmd.hsum_set = 1'b1;
                    state_next   = S_SYNC2;
                end
            end
            S_SYNC2:
            begin
                if (accept)
                begin
                    priority if (sts.sync2_hit)
                    begin
                        cmd.hsum_add = 1'b1;
                        state_next   = S_SIZE;
                    end
                    else if (sts.sync1_hit)
                    begin
                        cmd.hsum_set = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SYNC1;
                    end
                end
            end
            S_SIZE:
            begin
                if (accept)
                begin
                    cmd.size_set = 1'b1;
                    cmd.hsum_add = 1'b1;
                    state_next   = S_HCHK;
                end
            end
            S_HCHK:
            begin
                if (accept)
                begin
                    priority if (!sts.hdr_ok)
                    begin
                        cmd.out_status = 1'b1;
                        cmd.code       = sfcd_pkg::ST_HDR_BAD;
                        state_next     = S_SYNC1;
                    end
                    else if (sts.size_zero)
                    begin
                        cmd.out_status = 1'b1;
                        cmd.code       = sfcd_pkg::ST_EMPTY;
                        state_next     = S_SYNC1;
                    end
                    else if (sts.size_over)
                    begin
                        cmd.out_status = 1'b1;
                        cmd.code       = sfcd_pkg::ST_OVERSIZE;
                        state_next     = S_SYNC1;
                    end
                    else
                    begin
                        cmd.pay_clear = 1'b1;
                        state_next    = S_DATA;
                    end
                end
            end
            S_DATA:
            begin
                if (accept)
                begin
                    cmd.pay_write = 1'b1;
                    if (sts.pay_done)
                    begin
                        state_next = S_PCHK;
                    end
                end
            end
            S_PCHK:
            begin
                if (accept)
                begin
                    if (!sts.pay_ok)
                    begin
                        cmd.out_status = 1'b1;
                        cmd.code       = sfcd_pkg::ST_PAY_BAD;
                        state_next     = S_SYNC1;
                    end
                    else
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_data = 1'b1;
                    state_next   = sts.rd_last ? S_SYNC1 : S_RD;
                end
            end
            default:
            begin
                state_next = S_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/sfcd_dp.sv
module sfcd_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [7:0]          rx_byte,
    input  sfcd_pkg::sfcd_cmd_t cmd,
    output sfcd_pkg::sfcd_sts_t sts,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [7:0]          out_byte,
    output logic                is_command,
    output logic                last,
    output logic [2:0]          status
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]       first_sync_reg;
    logic [7:0]       second_sync_reg;
    logic [7:0]       hsum_reg;
    logic [7:0]       hsum_next;
    logic [7:0]       size_reg;
    logic [7:0]       size_next;
    logic [7:0]       psum_reg;
    logic [7:0]       psum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] rd_reg;
    logic [CNT_W-1:0] rd_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             is_command_reg;
    logic             is_command_next;
    logic             last_reg;
    logic             last_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [7:0]       ram_rdata;
    logic [7:0]       cnt_plus;
    logic [7:0]       rd_plus;

    assign cnt_plus = 8'(cnt_reg) + 8'd1;
    assign rd_plus  = 8'(rd_reg) + 8'd1;

    assign sts.sync1_hit = (rx_byte == first_sync_reg);
    assign sts.sync2_hit = (rx_byte == second_sync_reg);
    assign sts.hdr_ok    = (rx_byte == (8'd0 - hsum_reg));
    assign sts.size_zero = (size_reg == 8'd0);
    assign sts.size_over = (size_reg > 8'(MAX_PAYLOAD));
    assign sts.pay_done  = (cnt_plus >= size_reg);
    assign sts.pay_ok    = (rx_byte == (8'd0 - psum_reg));
    assign sts.rd_last   = (rd_plus == size_reg);
    assign sts.out_free  = !res_valid_reg || res_ready;

    sfcd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.pay_write),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        hsum_next = hsum_reg;
        if (cmd.hsum_set)
        begin
            hsum_next = rx_byte;
        end
        else if (cmd.hsum_add)
        begin
            hsum_next = hsum_reg + rx_byte;
        end

        size_next = cmd.size_set ? rx_byte : size_reg;

        psum_next = psum_reg;
        cnt_next  = cnt_reg;
        if (cmd.pay_clear)
        begin
            psum_next = 8'd0;
            cnt_next  = '0;
        end
        else if (cmd.pay_write)
        begin
            psum_next = psum_reg + rx_byte;
            cnt_next  = cnt_reg + 1'b1;
        end

        rd_next = rd_reg;
        if (cmd.rd_clear)
        begin
            rd_next = '0;
        end
        else if (cmd.out_data)
        begin
            rd_next = rd_reg + 1'b1;
        end

        res_valid_next  = res_valid_reg && !res_ready;
        out_byte_next   = out_byte_reg;
        is_command_next = is_command_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        if (cmd.out_data)
        begin
            res_valid_next  = 1'b1;
            out_byte_next   = ram_rdata;
            is_command_next = (rd_reg == '0);
            last_next       = sts.rd_last;
            status_next     = sfcd_pkg::ST_OK;
        end
        else if (cmd.out_status)
        begin
            res_valid_next  = 1'b1;
            out_byte_next   = 8'd0;
            is_command_next = 1'b0;
            last_next       = 1'b1;
            status_next     = cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= sfcd_pkg::FIRST_SYNC_RESET;
            second_sync_reg <= sfcd_pkg::SECOND_SYNC_RESET;
            hsum_reg        <= 8'd0;
            size_reg        <= 8'd0;
            psum_reg        <= 8'd0;
            cnt_reg         <= '0;
            rd_reg          <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == sfcd_pkg::CFG_FIRST_SYNC))
            begin
                first_sync_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == sfcd_pkg::CFG_SECOND_SYNC))
            begin
                second_sync_reg <= cfg_data;
            end
            hsum_reg      <= hsum_next;
            size_reg      <= size_next;
            psum_reg      <= psum_next;
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        is_command_reg <= is_command_next;
        last_reg       <= last_next;
        status_reg     <= status_next;
    end

    assign res_valid  = res_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_command = is_command_reg;
    assign last       = last_reg;
    assign status     = status_reg;

endmodule

// File: sv/sync_framed_command_deframer_unit.sv
// A status word is offered in the cycle after the checksum byte that decides it.
// A good frame offers its first payload word after the payload checksum byte, a store read
// and an output load. Throughput: one received word per cycle while the result register
// is free and no frame drains; per word a drain reads the store, then loads or stalls.
// Reset: hunt for the first sync byte, sync values 0xFF and 0x55, payload store not cleared.
module sync_framed_command_deframer_unit #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_byte,
    output logic       is_command,
    output logic       last,
    output logic [2:0] status
);

    sfcd_pkg::sfcd_cmd_t cmd;
    sfcd_pkg::sfcd_sts_t sts;

    assign cfg_ready = 1'b1;

    sfcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfcd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .is_command (is_command),
        .last       (last),
        .status     (status)
    );

endmodule

// File: sv/sfcd_chk.sv
module sfcd_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic       is_command,
    input logic       last,
    input logic [2:0] status
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(status))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != sfcd_pkg::ST_OK) |-> last && !is_command && (out_byte == 8'd0))
        else $error("status word malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_command |-> (status == sfcd_pkg::ST_OK))
        else $error("command flag on a status word");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status <= sfcd_pkg::ST_EMPTY))
        else $error("status code out of range");

endmodule

bind sync_framed_command_deframer_unit sfcd_chk u_sfcd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_byte   (out_byte),
    .is_command (is_command),
    .last       (last),
    .status     (status)
);

// File: verif/testbench.sv
module testbench;

    localparam int MAX_PAYLOAD = 32;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [7:0] CFG_SPARE_LOW  = 8'h02;
    localparam logic [7:0] CFG_SPARE_HIGH = 8'hFE;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_SIZE,
        TAKE_HDR_SUM,
        TAKE_PAYLOAD,
        TAKE_PAY_SUM
    } frame_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       cmd;
        logic       lst;
        logic [2:0] code;
    } deframed_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;
    logic [2:0] status;

    sync_framed_command_deframer_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_byte  (out_byte),
        .is_command(is_command),
        .last      (last),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Deframer prediction state
    logic [7:0]     sync_first_cfg = sfcd_pkg::FIRST_SYNC_RESET;
    logic [7:0]     sync_second_cfg = sfcd_pkg::SECOND_SYNC_RESET;
    frame_phase_t   hunt_phase = HUNT_FIRST;
    logic [7:0]     hdr_sum = 8'h00;
    logic [7:0]     size_seen = 8'h00;
    logic [7:0]     pay_sum = 8'h00;
    int             pay_count = 0;
    logic [7:0]     pay_store [MAX_PAYLOAD];
    deframed_word_t expected_words [$];

    int error_count = 0;
    int items_sent = 0;
    int rx_idle_pct = 0;
    int res_stall_pct = 0;
    int quiet_cycles = 0;

    task report_mismatch(input string msg);
        if (error_count < 100)
            $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task push_status(input logic [2:0] code);
        expected_words.push_back('{data: 8'h00, cmd: 1'b0, lst: 1'b1, code: code});
        hunt_phase = HUNT_FIRST;
    endtask

    task deframe_byte(input logic [7:0] b);
        int i;
        case (hunt_phase)
            HUNT_FIRST:
            begin
                if (b == sync_first_cfg)
                begin
                    hdr_sum = b;
                    hunt_phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                if (b == sync_second_cfg)
                begin
                    hdr_sum = hdr_sum + b;
                    hunt_phase = TAKE_SIZE;
                end
                else if (b == sync_first_cfg)
                    hdr_sum = b;
                else
                    hunt_phase = HUNT_FIRST;
            end
            TAKE_SIZE:
            begin
                size_seen = b;
                hdr_sum = hdr_sum + b;
                hunt_phase = TAKE_HDR_SUM;
            end
            TAKE_HDR_SUM:
            begin
                if (b != 8'(8'h00 - hdr_sum))
                    push_status(sfcd_pkg::ST_HDR_BAD);
                else if (size_seen == 8'h00)
                    push_status(sfcd_pkg::ST_EMPTY);
                else if (int'(size_seen) > MAX_PAYLOAD)
                    push_status(sfcd_pkg::ST_OVERSIZE);
                else
                begin
                    pay_sum = 8'h00;
                    pay_count = 0;
                    hunt_phase = TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                if (pay_count < MAX_PAYLOAD)
                    pay_store[pay_count] = b;
                pay_sum = pay_sum + b;
                pay_count++;
                if (pay_count >= int'(size_seen))
                    hunt_phase = TAKE_PAY_SUM;
            end
            TAKE_PAY_SUM:
            begin
                if (b != 8'(8'h00 - pay_sum))
                    push_status(sfcd_pkg::ST_PAY_BAD);
                else
                begin
                    for (i = 0; i < int'(size_seen) && i < MAX_PAYLOAD; i++)
                        expected_words.push_back('{data: pay_store[i], cmd: (i == 0),
                                                   lst: (i + 1 == int'(size_seen)),
                                                   code: sfcd_pkg::ST_OK});
                    hunt_phase = HUNT_FIRST;
                end
            end
            default: hunt_phase = HUNT_FIRST;
        endcase
    endtask

    always @(posedge clk)
    begin : check_words
        deframed_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word byte=%h cmd=%b last=%b status=%0d",
                                          out_byte, is_command, last, status));
            else
            begin
                want = expected_words.pop_front();
                if (out_byte !== want.data || is_command !== want.cmd ||
                    last !== want.lst || status !== want.code)
                    report_mismatch($sformatf(
                        "got %h/%b/%b/%0d, want %h/%b/%b/%0d (byte/cmd/last/status)",
                        out_byte, is_command, last, status,
                        want.data, want.cmd, want.lst, want.code));
            end
        end
    end

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= res_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && rx_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < rx_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        deframe_byte(b);
        items_sent++;
    endtask

    task drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task write_register(input logic [7:0] idx, input logic [7:0] value);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == sfcd_pkg::CFG_FIRST_SYNC)
            sync_first_cfg = value;
        else if (idx == sfcd_pkg::CFG_SECOND_SYNC)
            sync_second_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    task send_header(input logic [7:0] size_byte, input bit bad_sum);
        logic [7:0] chk;
        chk = 8'h00 - (sync_first_cfg + sync_second_cfg + size_byte);
        if (bad_sum)
            chk = chk ^ (8'h01 << $urandom_range(7));
        send_byte(sync_first_cfg);
        send_byte(sync_second_cfg);
        send_byte(size_byte);
        send_byte(chk);
    endtask

    task send_frame(input logic [7:0] size_byte, input bit bad_hdr, input bit bad_pay,
                    input bit use_fixed, input logic [7:0] fixed);
        logic [7:0] sum;
        logic [7:0] data;
        int i;
        send_header(size_byte, bad_hdr);
        if (!bad_hdr && size_byte != 8'h00 && int'(size_byte) <= MAX_PAYLOAD)
        begin
            sum = 8'h00;
            for (i = 0; i < int'(size_byte); i++)
            begin
                data = use_fixed ? fixed : 8'($urandom_range(255));
                sum = sum + data;
                send_byte(data);
            end
            sum = 8'h00 - sum;
            if (bad_pay)
                sum = sum ^ (8'h01 << $urandom_range(7));
            send_byte(sum);
        end
    endtask

    task test_default_sync();
        send_byte(8'h12);
        send_byte(sfcd_pkg::SECOND_SYNC_RESET);
        send_byte(sfcd_pkg::FIRST_SYNC_RESET);
        send_byte(8'h00);
        // repeated first sync byte restarts the header
        send_byte(sfcd_pkg::FIRST_SYNC_RESET);
        send_frame(8'd1, 1'b0, 1'b0, 1'b1, 8'hFF);
    endtask

    task test_header_checks();
        send_frame(8'd0, 1'b0, 1'b0, 1'b0, 8'h00);
        send_frame(8'd0, 1'b1, 1'b0, 1'b0, 8'h00);
        send_frame(8'd33, 1'b0, 1'b0, 1'b0, 8'h00);
        send_frame(8'd255, 1'b0, 1'b0, 1'b0, 8'h00);
        send_frame(8'd40, 1'b1, 1'b0, 1'b0, 8'h00);
    endtask

    task test_payload_check();
        send_frame(8'd2, 1'b0, 1'b1, 1'b1, 8'h00);
        send_frame(8'd2, 1'b0, 1'b0, 1'b1, 8'h00);
    endtask

    task test_sync_registers();
        write_register(sfcd_pkg::CFG_FIRST_SYNC, 8'h00);
        write_register(sfcd_pkg::CFG_SECOND_SYNC, 8'hFF);
        send_frame(8'd1, 1'b0, 1'b0, 1'b0, 8'h00);
        write_register(sfcd_pkg::CFG_SECOND_SYNC, 8'h00);
        send_frame(8'd1, 1'b0, 1'b0, 1'b0, 8'h00);
        // spare indexes must leave the sync values alone
        write_register(CFG_SPARE_LOW, 8'hFF);
        write_register(CFG_SPARE_HIGH, 8'h5A);
        send_frame(8'd1, 1'b0, 1'b0, 1'b0, 8'h00);
        write_register(sfcd_pkg::CFG_FIRST_SYNC, sfcd_pkg::FIRST_SYNC_RESET);
        write_register(sfcd_pkg::CFG_SECOND_SYNC, sfcd_pkg::SECOND_SYNC_RESET);
    endtask

    task test_random_traffic(input int n_items, input int idle_pct, input int stall_pct,
                             input logic [7:0] s1, input logic [7:0] s2);
        int start;
        int pick;
        int r;
        int n;
        logic [7:0] size_byte;
        bit first_frame;
        write_register(sfcd_pkg::CFG_FIRST_SYNC, s1);
        write_register(sfcd_pkg::CFG_SECOND_SYNC, s2);
        rx_idle_pct = idle_pct;
        res_stall_pct = stall_pct;
        first_frame = 1'b1;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 8)
                drain_results();
            r = $urandom_range(9);
            if (first_frame || r == 0)
                size_byte = 8'd32;
            else if (r < 4)
                size_byte = 8'($urandom_range(31, 7));
            else
                size_byte = 8'($urandom_range(6, 1));
            first_frame = 1'b0;
            pick = $urandom_range(99);
            if (pick < 66)
                send_frame(size_byte, 1'b0, 1'b0, 1'b0, 8'h00);
            else if (pick < 74)
                send_frame(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 8'h00);
            else if (pick < 82)
                send_frame(size_byte, 1'b0, 1'b1, 1'b0, 8'h00);
            else if (pick < 86)
                send_frame(8'd0, 1'b0, 1'b0, 1'b0, 8'h00);
            else if (pick < 90)
                send_frame(8'($urandom_range(255, 33)), 1'b0, 1'b0, 1'b0, 8'h00);
            else if (pick < 95)
            begin
                n = $urandom_range(6, 1);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
            else
            begin
                // cut a frame short; the next frame gets swallowed as payload
                size_byte = 8'($urandom_range(8, 2));
                send_header(size_byte, 1'b0);
                n = $urandom_range(int'(size_byte) - 1);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_default_sync();
        test_header_checks();
        test_payload_check();
        test_sync_registers();
        test_random_traffic(40, 0, 0, sfcd_pkg::FIRST_SYNC_RESET, sfcd_pkg::SECOND_SYNC_RESET);
        test_random_traffic(40, 58, 0, 8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_traffic(40, 0, 58, 8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_traffic(40, 6, 6, 8'($urandom_range(255)), 8'($urandom_range(255)));
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sync_framed_command_deframer_unit.f
sv/sfcd_pkg.sv
sv/sfcd_ram.sv
sv/sfcd_ctrl.sv
sv/sfcd_dp.sv
sv/sync_framed_command_deframer_unit.sv
sv/sfcd_chk.sv
verif/testbench.sv
